>>> sv/stack_machine_execute_unit_defines.svh
// Assertion macros for the stack machine execute unit.
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SME_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SME_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SME_ASSERT(lbl, prop, msg)
`define SME_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/sme_pkg.sv
// Shared constants, codes and types of the stack machine execute unit.
`default_nettype none
package sme_pkg;
    localparam int STACK_DEPTH = 1024;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int MODE_W      = 4;
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_LT   = 4'd5,
        OP_LE   = 4'd6,
        OP_EQ   = 4'd7,
        OP_DUP  = 4'd8,
        OP_DROP = 4'd9,
        OP_SWAP = 4'd10,
        OP_NOP  = 4'd11
    } t_op_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_DIV_ZERO  = 2'd3
    } t_status_e;

    typedef struct packed {
        t_op_e             op;
        logic              needs_two;
        logic              needs_one;
        logic              grows;
        logic [DATA_W-1:0] imm;
    } t_cmd_s;
endpackage
`default_nettype wire

>>> sv/sme_if.sv
// Valid/ready channel interfaces for operations in and results out.
`default_nettype none
interface sme_in_if import sme_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] immediate;
    modport source (output valid, output mode, output immediate, input ready);
    modport sink   (input valid, input mode, input immediate, output ready);
endinterface

interface sme_out_if import sme_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    modport source (output valid, output status, output top_value, output depth, input ready);
    modport sink   (input valid, input status, input top_value, input depth, output ready);
endinterface
`default_nettype wire

>>> sv/sme_front.sv
// Front end: accept operations and classify them into commands.
`default_nettype none
module sme_front import sme_pkg::*; (
    sme_in_if.sink  i_op,
    output logic    o_cmd_valid,
    input  logic    i_cmd_ready,
    output t_cmd_s  o_cmd
);
    t_op_e op;

    always_comb begin
        if (i_op.mode > MODE_W'(OP_NOP)) begin
            op = OP_NOP;
        end else begin
            op = t_op_e'(i_op.mode);
        end
    end

    always_comb begin
        o_cmd.op        = op;
        o_cmd.imm       = i_op.immediate;
        o_cmd.needs_two = 1'b0;
        o_cmd.needs_one = 1'b0;
        o_cmd.grows     = 1'b0;
        case (op)
            OP_PUSH: begin
                o_cmd.grows = 1'b1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_LE, OP_EQ, OP_SWAP: begin
                o_cmd.needs_two = 1'b1;
            end
            OP_DUP: begin
                o_cmd.needs_one = 1'b1;
                o_cmd.grows     = 1'b1;
            end
            OP_DROP: begin
                o_cmd.needs_one = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_cmd_valid = i_op.valid;
    assign i_op.ready  = i_cmd_ready;
endmodule
`default_nettype wire

>>> sv/sme_queue.sv
// Short command queue between front end and back end.
`default_nettype none
module sme_queue import sme_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr_valid,
    output logic   o_wr_ready,
    input  t_cmd_s i_wr_data,
    output logic   o_rd_valid,
    input  logic   i_rd_ready,
    output t_cmd_s o_rd_data
);
    t_cmd_s            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_wr_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

>>> sv/sme_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module sme_div import sme_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;
    logic              r_done;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   rem_diff;
    logic [DATA_W-1:0] a_abs;
    logic [DATA_W-1:0] b_abs;

    assign a_abs     = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign b_abs     = i_divisor[DATA_W-1]  ? (~i_divisor + 1'b1)  : i_divisor;
    assign rem_shift = {r_rem, r_quo[DATA_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_W'(DATA_W - 1);
                r_rem   <= '0;
                r_quo   <= a_abs;
                r_den   <= b_abs;
                r_neg   <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            end else if (r_busy) begin
                if (!rem_diff[DATA_W]) begin
                    r_rem <= rem_diff[DATA_W-1:0];
                    r_quo <= {r_quo[DATA_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_shift[DATA_W-1:0];
                    r_quo <= {r_quo[DATA_W-2:0], 1'b0};
                end
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;
endmodule
`default_nettype wire

>>> sv/sme_back.sv
// Back end: operand stack memory, top register, ALU and result register.
`default_nettype none
`include "stack_machine_execute_unit_defines.svh"
module sme_back import sme_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd_s    i_cmd,
    sme_out_if.source o_res
);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV} t_state_e;

    t_state_e           r_state;
    logic [DEPTH_W-1:0] r_depth;
    logic [DATA_W-1:0]  r_top;
    t_cmd_s             r_cmd;
    logic [DATA_W-1:0]  r_rd_data;
    logic [DATA_W-1:0]  r_mem [STACK_DEPTH];
    logic               r_div_start;
    logic               r_out_valid;
    t_status_e          r_out_status;
    logic [DATA_W-1:0]  r_out_top;
    logic [DEPTH_W-1:0] r_out_depth;

    logic [DEPTH_W-1:0] depth_p1;
    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_m2;
    logic [DATA_W-1:0]  top_cur;
    logic               take;
    t_status_e          chk_status;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [DATA_W-1:0]  alu_res;
    logic               div_done;
    logic [DATA_W-1:0]  div_quo;

    assign depth_p1 = r_depth + 1'b1;
    assign depth_m1 = r_depth - 1'b1;
    assign depth_m2 = r_depth - 2'd2;
    assign top_cur  = (r_depth == '0) ? '0 : r_top;
    assign take     = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || o_res.ready);
    assign o_cmd_ready = take;

    always_comb begin
        if (i_cmd.needs_two && (r_depth < DEPTH_W'(2))) begin
            chk_status = ST_UNDERFLOW;
        end else if (i_cmd.needs_one && (r_depth == '0)) begin
            chk_status = ST_UNDERFLOW;
        end else if (i_cmd.grows && (r_depth >= DEPTH_W'(STACK_DEPTH))) begin
            chk_status = ST_OVERFLOW;
        end else begin
            chk_status = ST_OK;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = depth_m1[ADDR_W-1:0];
        if (take && (chk_status == ST_OK) && (r_depth != '0) &&
            ((i_cmd.op == OP_PUSH) || (i_cmd.op == OP_DUP))) begin
            mem_we = 1'b1;
        end else if ((r_state == S_READ) && (r_cmd.op == OP_SWAP)) begin
            mem_we    = 1'b1;
            mem_waddr = depth_m2[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_top;
        end
        r_rd_data <= r_mem[depth_m2[ADDR_W-1:0]];
    end

    always_comb begin
        case (r_cmd.op)
            OP_ADD:  alu_res = r_rd_data + r_top;
            OP_SUB:  alu_res = r_rd_data - r_top;
            OP_MUL:  alu_res = r_rd_data * r_top;
            OP_LT:   alu_res = {{(DATA_W-1){1'b0}}, ($signed(r_rd_data) < $signed(r_top))};
            OP_LE:   alu_res = {{(DATA_W-1){1'b0}}, ($signed(r_rd_data) <= $signed(r_top))};
            OP_EQ:   alu_res = {{(DATA_W-1){1'b0}}, (r_rd_data == r_top)};
            default: alu_res = r_top;
        endcase
    end

    sme_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_rd_data),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_cmd <= i_cmd;
                        if (chk_status != ST_OK) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= chk_status;
                            r_out_top    <= top_cur;
                            r_out_depth  <= r_depth;
                        end else begin
                            case (i_cmd.op)
                                OP_PUSH: begin
                                    r_top        <= i_cmd.imm;
                                    r_depth      <= depth_p1;
                                    r_out_valid  <= 1'b1;
                                    r_out_status <= ST_OK;
                                    r_out_top    <= i_cmd.imm;
                                    r_out_depth  <= depth_p1;
                                end
                                OP_DUP: begin
                                    r_depth      <= depth_p1;
                                    r_out_valid  <= 1'b1;
                                    r_out_status <= ST_OK;
                                    r_out_top    <= r_top;
                                    r_out_depth  <= depth_p1;
                                end
                                OP_DROP: begin
                                    if (r_depth == DEPTH_W'(1)) begin
                                        r_depth      <= '0;
                                        r_out_valid  <= 1'b1;
                                        r_out_status <= ST_OK;
                                        r_out_top    <= '0;
                                        r_out_depth  <= '0;
                                    end else begin
                                        r_state <= S_READ;
                                    end
                                end
                                OP_NOP: begin
                                    r_out_valid  <= 1'b1;
                                    r_out_status <= ST_OK;
                                    r_out_top    <= top_cur;
                                    r_out_depth  <= r_depth;
                                end
                                default: begin
                                    r_state <= S_READ;
                                end
                            endcase
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_IDLE;
                    case (r_cmd.op)
                        OP_DROP: begin
                            r_top        <= r_rd_data;
                            r_depth      <= depth_m1;
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_OK;
                            r_out_top    <= r_rd_data;
                            r_out_depth  <= depth_m1;
                        end
                        OP_SWAP: begin
                            r_top        <= r_rd_data;
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_OK;
                            r_out_top    <= r_rd_data;
                            r_out_depth  <= r_depth;
                        end
                        OP_DIV: begin
                            if (r_top == '0) begin
                                r_out_valid  <= 1'b1;
                                r_out_status <= ST_DIV_ZERO;
                                r_out_top    <= r_top;
                                r_out_depth  <= r_depth;
                            end else begin
                                r_div_start <= 1'b1;
                                r_state     <= S_DIV;
                            end
                        end
                        default: begin
                            r_top        <= alu_res;
                            r_depth      <= depth_m1;
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_OK;
                            r_out_top    <= alu_res;
                            r_out_depth  <= depth_m1;
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        r_top        <= div_quo;
                        r_depth      <= depth_m1;
                        r_out_valid  <= 1'b1;
                        r_out_status <= ST_OK;
                        r_out_top    <= div_quo;
                        r_out_depth  <= depth_m1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_out_status;
    assign o_res.top_value = r_out_top;
    assign o_res.depth     = r_out_depth;

    `SME_ASSERT(a_depth_bound, (r_depth <= DEPTH_W'(STACK_DEPTH)), "stack depth beyond capacity")
    `SME_ASSERT(a_read_slot_free, (r_state == S_READ) |-> !r_out_valid, "result slot busy in read")
    `SME_ASSERT(a_div_done_state, div_done |-> (r_state == S_DIV), "divider done outside divide")
    `SME_ASSERT(a_depth_step, (r_depth == $past(r_depth)) || (r_depth == $past(r_depth) + 1'b1) || (r_depth == $past(r_depth) - 1'b1), "depth moved by more than one")
    `SME_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE) && !r_out_valid, "not idle after reset")
endmodule
`default_nettype wire

>>> sv/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit.
// Usage:
//   i_op carries one decoded operation per transfer (mode, immediate);
//   o_res returns exactly one result per operation (status, top_value,
//   depth), in order. Both channels transfer when valid and ready are high.
//   Accepted operations enter a two-entry command queue; the back end pulls
//   them one at a time and works on the 1024-entry operand stack, held as a
//   top register plus a memory with one write port and a registered read.
// Path from input transfer to result valid:
//   push, dup, nop, and any underflow/overflow: result set in the idle state.
//   add, sub, mul, lt, le, eq, swap, drop with entries below: via the read state.
//   div: divide by zero reported from the read state, otherwise via the iterative
//   divider, which retires one quotient bit per cycle.
// Throughput: one operation per cycle for push/dup/nop while results are taken;
//   other ops hold the back end until their result is set, then it takes the next.
// Reset (synchronous, active low) empties the stack and drops any queued
//   operation or pending result; no clearing pass is needed.
// A stalled receiver holds the result register; the back end waits, and the
//   queue then fills and drops i_op.ready.
`default_nettype none
module stack_machine_execute_unit import sme_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sme_in_if.sink    i_op,
    sme_out_if.source o_res
);
    logic   f_cmd_valid;
    logic   f_cmd_ready;
    t_cmd_s f_cmd;
    logic   q_cmd_valid;
    logic   q_cmd_ready;
    t_cmd_s q_cmd;

    sme_front u_front (
        .i_op        (i_op),
        .o_cmd_valid (f_cmd_valid),
        .i_cmd_ready (f_cmd_ready),
        .o_cmd       (f_cmd)
    );

    sme_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_cmd_valid),
        .o_wr_ready (f_cmd_ready),
        .i_wr_data  (f_cmd),
        .o_rd_valid (q_cmd_valid),
        .i_rd_ready (q_cmd_ready),
        .o_rd_data  (q_cmd)
    );

    sme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_cmd_valid),
        .o_cmd_ready (q_cmd_ready),
        .i_cmd       (q_cmd),
        .o_res       (o_res)
    );
endmodule
`default_nettype wire
